/* rtl/core/tieq_pkg.sv */
// shared types, codes and widths for the timestamped input event queues
package tieq_pkg;

	localparam int DEVICES_DEF    = 4;
	localparam int RING_DEPTH_DEF = 64;
	localparam int TICK_RATE_DEF  = 100;

	localparam int MODE_W   = 3;
	localparam int DEVICE_W = 2;
	localparam int CODE_W   = 16;
	localparam int VALUE_W  = 32;
	localparam int WANT_W   = 7;
	localparam int STATUS_W = 2;
	localparam int SEC_W    = 58;
	localparam int USEC_W   = 20;
	localparam int ETYPE_W  = 2;
	localparam int REM_W    = 7;
	localparam int TICK_W   = 64;
	localparam int ENABLE_W = 4;

	localparam int MAX_RESULTS  = 64;
	localparam int USEC_PER_SEC = 1000000;
	localparam int CMDQ_DEPTH   = 4;

	localparam logic [ENABLE_W-1:0] ENABLE_RESET = 4'd3;
	localparam logic [CODE_W-1:0]   AXIS_X       = 16'd0;
	localparam logic [CODE_W-1:0]   AXIS_Y       = 16'd1;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK   = 3'd0,
		MODE_KEY    = 3'd1,
		MODE_REL    = 3'd2,
		MODE_BUTTON = 3'd3,
		MODE_READ   = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_EVENT = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_BAD   = 2'd2
	} status_t;

	typedef enum logic [ETYPE_W-1:0] {
		ETYPE_SYN = 2'd0,
		ETYPE_KEY = 2'd1,
		ETYPE_REL = 2'd2
	} etype_t;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_READ = 1'b1
	} cmd_kind_t;

	typedef enum logic {
		B_IDLE = 1'b0,
		B_LOAD = 1'b1
	} back_state_t;

	typedef struct packed {
		logic [MODE_W-1:0]          mode;
		logic [DEVICE_W-1:0]        device;
		logic [CODE_W-1:0]          code;
		logic signed [VALUE_W-1:0]  value;
		logic signed [VALUE_W-1:0]  dx;
		logic signed [VALUE_W-1:0]  dy;
		logic [WANT_W-1:0]          pop_limit;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]        status;
		logic [SEC_W-1:0]           stamp_sec;
		logic [USEC_W-1:0]          stamp_usec;
		logic [ETYPE_W-1:0]         event_type;
		logic [CODE_W-1:0]          event_code;
		logic signed [VALUE_W-1:0]  event_value;
		logic [REM_W-1:0]           remaining;
		logic                       last;
	} res_t;

	typedef struct packed {
		logic [SEC_W-1:0]           sec;
		logic [USEC_W-1:0]          usec;
		etype_t                     etype;
		logic [CODE_W-1:0]          code;
		logic signed [VALUE_W-1:0]  value;
	} evt_t;

	typedef struct packed {
		cmd_kind_t                  kind;
		logic [DEVICE_W-1:0]        dev;
		logic                       bad;
		logic [WANT_W-1:0]          want;
		evt_t                       evt;
	} cmd_t;

endpackage

/* rtl/core/tieq_chan_if.sv */
// valid/ready channel carrying one payload per beat
interface tieq_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/tieq_front.sv */
// front end: tick clock, enable register and expansion of items into ring commands
module tieq_front import tieq_pkg::*; #(
	parameter int DEVICES   = DEVICES_DEF,
	parameter int TICK_RATE = TICK_RATE_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tieq_chan_if.sink  req,
	tieq_chan_if.sink  cfg,
	tieq_chan_if.source cmd
);

	localparam int FRAC_W    = (TICK_RATE > 1) ? $clog2(TICK_RATE) : 1;
	localparam int USEC_STEP = USEC_PER_SEC / TICK_RATE;
	localparam int RES_STEP  = USEC_PER_SEC % TICK_RATE;

	localparam int PEND_A   = 0;
	localparam int PEND_Y   = 1;
	localparam int PEND_SYN = 2;
	localparam int PEND_RD  = 3;
	localparam int PEND_W   = 4;

	logic [ENABLE_W-1:0] enable_q;
	logic [TICK_W-1:0]   tick_q;
	logic [SEC_W-1:0]    sec_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [USEC_W-1:0]   usec_q;
	logic [FRAC_W-1:0]   res_q;

	logic [PEND_W-1:0]   pend_q;
	logic [PEND_W-1:0]   new_pend;
	logic [PEND_W-1:0]   low_bit;
	logic                single;
	logic                acc;
	logic                emit;
	logic                tick_adv;

	logic [DEVICE_W-1:0]       dev_d, dev_q;
	etype_t                    a_etype_d, a_etype_q;
	logic [CODE_W-1:0]         a_code_d, a_code_q;
	logic signed [VALUE_W-1:0] a_value_d, a_value_q;
	logic signed [VALUE_W-1:0] y_value_q;
	logic [WANT_W-1:0]         want_d, want_q;
	logic                      bad_d, bad_q;

	logic [FRAC_W:0]     res_sum;
	logic                res_wrap;
	logic [USEC_W-1:0]   usec_next;
	logic [FRAC_W-1:0]   res_next;

	evt_t                evt;

	assign acc      = req.valid && req.ready;
	assign low_bit  = pend_q & (~pend_q + 4'd1);
	assign single   = (pend_q & (pend_q - 4'd1)) == '0;
	assign emit     = cmd.valid && cmd.ready;
	assign req.ready = (pend_q == '0) || (cmd.ready && single);
	assign cfg.ready = 1'b1;
	assign tick_adv = acc && (req.data.mode == MODE_TICK);

	// decode the item being taken
	always_comb begin
		new_pend  = '0;
		dev_d     = '0;
		a_etype_d = ETYPE_KEY;
		a_code_d  = req.data.code;
		a_value_d = req.data.value;
		want_d    = (req.data.pop_limit > WANT_W'(MAX_RESULTS)) ?
			WANT_W'(MAX_RESULTS) : req.data.pop_limit;
		bad_d     = (32'(req.data.device) >= DEVICES) || !enable_q[req.data.device];
		case (req.data.mode)
			MODE_KEY: begin
				new_pend[PEND_A]   = enable_q[0];
				new_pend[PEND_SYN] = enable_q[0];
				dev_d              = DEVICE_W'(0);
			end
			MODE_BUTTON: begin
				new_pend[PEND_A]   = enable_q[1];
				new_pend[PEND_SYN] = enable_q[1];
				dev_d              = DEVICE_W'(1);
			end
			MODE_REL: begin
				new_pend[PEND_A]   = enable_q[1] && (req.data.dx != '0);
				new_pend[PEND_Y]   = enable_q[1] && (req.data.dy != '0);
				new_pend[PEND_SYN] = enable_q[1];
				dev_d              = DEVICE_W'(1);
				a_etype_d          = ETYPE_REL;
				a_code_d           = AXIS_X;
				a_value_d          = req.data.dx;
			end
			MODE_READ: begin
				new_pend[PEND_RD] = 1'b1;
				dev_d             = req.data.device;
			end
			default: begin
				new_pend = '0;
			end
		endcase
	end

	// lowest pending command goes out first: event a, y, sync, then read
	always_comb begin
		evt.sec   = sec_q;
		evt.usec  = usec_q;
		evt.etype = ETYPE_SYN;
		evt.code  = '0;
		evt.value = '0;
		if (pend_q[PEND_A]) begin
			evt.etype = a_etype_q;
			evt.code  = a_code_q;
			evt.value = a_value_q;
		end else if (pend_q[PEND_Y]) begin
			evt.etype = ETYPE_REL;
			evt.code  = AXIS_Y;
			evt.value = y_value_q;
		end
		cmd.valid     = pend_q != '0;
		cmd.data.kind = (low_bit == PEND_W'(1 << PEND_RD)) ? CMD_READ : CMD_PUSH;
		cmd.data.dev  = dev_q;
		cmd.data.bad  = bad_q;
		cmd.data.want = want_q;
		cmd.data.evt  = evt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (acc) begin
			pend_q <= new_pend;
		end else if (emit) begin
			pend_q <= pend_q & ~low_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			dev_q     <= dev_d;
			a_etype_q <= a_etype_d;
			a_code_q  <= a_code_d;
			a_value_q <= a_value_d;
			y_value_q <= req.data.dy;
			want_q    <= want_d;
			bad_q     <= bad_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= ENABLE_RESET;
		end else if (cfg.valid) begin
			enable_q <= cfg.data;
		end
	end

	// seconds and microseconds kept alongside the raw count, so no divider is needed
	assign res_sum   = {1'b0, res_q} + (FRAC_W+1)'(RES_STEP);
	assign res_wrap  = res_sum >= (FRAC_W+1)'(TICK_RATE);
	assign usec_next = usec_q + USEC_W'(USEC_STEP) + USEC_W'(res_wrap);
	assign res_next  = res_wrap ? FRAC_W'(res_sum - (FRAC_W+1)'(TICK_RATE)) : FRAC_W'(res_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			sec_q  <= '0;
			frac_q <= '0;
			usec_q <= '0;
			res_q  <= '0;
		end else if (tick_adv) begin
			tick_q <= tick_q + TICK_W'(1);
			if (&tick_q) begin
				// count wraps to zero
				sec_q  <= '0;
				frac_q <= '0;
				usec_q <= '0;
				res_q  <= '0;
			end else if (frac_q == FRAC_W'(TICK_RATE - 1)) begin
				sec_q  <= sec_q + SEC_W'(1);
				frac_q <= '0;
				usec_q <= '0;
				res_q  <= '0;
			end else begin
				frac_q <= frac_q + FRAC_W'(1);
				usec_q <= usec_next;
				res_q  <= res_next;
			end
		end
	end

endmodule

/* rtl/core/tieq_cmdq.sv */
// short command queue between the front end and the ring engine
module tieq_cmdq import tieq_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	tieq_chan_if.sink   wr,
	tieq_chan_if.source rd
);

	localparam int PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             slot_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign wr.ready = cnt_q != CNT_W'(CMDQ_DEPTH);
	assign rd.valid = cnt_q != '0;
	assign rd.data  = slot_q[rd_ptr_q];
	assign push     = wr.valid && wr.ready;
	assign pop      = rd.valid && rd.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

/* rtl/core/tieq_back.sv */
// ring engine: per-device rings in one memory, pushes and streamed pops
module tieq_back import tieq_pkg::*; #(
	parameter int DEVICES    = DEVICES_DEF,
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	tieq_chan_if.sink   cmd,
	tieq_chan_if.source rsp
);

	localparam int DEV_W = $clog2(DEVICES);
	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int CNT_W = $clog2(RING_DEPTH + 1);

	evt_t             ring_mem [DEVICES][RING_DEPTH];
	evt_t             rd_q;

	logic [PTR_W-1:0] wp_q  [DEVICES];
	logic [PTR_W-1:0] rp_q  [DEVICES];
	logic [CNT_W-1:0] cnt_q [DEVICES];

	back_state_t      state_q, state_d;
	logic [DEV_W-1:0] dev_q;
	logic [CNT_W-1:0] rem_q;
	logic             last_q;
	logic [WANT_W-1:0] left_q;

	logic             out_valid_q;
	res_t             out_q;

	logic [DEV_W-1:0] idx;
	logic [PTR_W-1:0] wp_cur, rp_cur, wp_inc, rp_inc;
	logic [CNT_W-1:0] cnt_cur;
	logic             out_free;
	logic             head_read;
	logic             head_start;

	logic             cmd_pop;
	logic             do_push;
	logic             do_pop;
	logic             load_evt;
	logic             load_stat;
	status_t          stat_code;
	logic [REM_W-1:0] stat_rem;
	logic [WANT_W-1:0] left_src;
	logic [CNT_W-1:0] meta_rem;
	logic             meta_last;
	logic [WANT_W-1:0] meta_left;

	assign idx       = (state_q == B_LOAD) ? dev_q : DEV_W'(cmd.data.dev);
	assign wp_cur    = wp_q[idx];
	assign rp_cur    = rp_q[idx];
	assign cnt_cur   = cnt_q[idx];
	assign wp_inc    = (wp_cur == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_cur + PTR_W'(1);
	assign rp_inc    = (rp_cur == PTR_W'(RING_DEPTH - 1)) ? '0 : rp_cur + PTR_W'(1);
	assign out_free  = !out_valid_q || rsp.ready;
	assign head_read = cmd.valid && (cmd.data.kind == CMD_READ);
	assign head_start = head_read && !cmd.data.bad && (cmd.data.want != '0) && (cnt_cur != '0);

	assign left_src  = (state_q == B_LOAD) ? left_q : cmd.data.want;
	assign meta_rem  = cnt_cur - CNT_W'(1);
	assign meta_last = (left_src == WANT_W'(1)) || (cnt_cur == CNT_W'(1));
	assign meta_left = left_src - WANT_W'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (head_start) begin
					state_d = B_LOAD;
				end
			end
			B_LOAD: begin
				if (out_free && last_q) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		do_push   = 1'b0;
		do_pop    = 1'b0;
		load_evt  = 1'b0;
		load_stat = 1'b0;
		stat_code = STAT_EMPTY;
		stat_rem  = '0;
		case (state_q)
			B_IDLE: begin
				if (cmd.valid && (cmd.data.kind == CMD_PUSH)) begin
					// full ring drops the event
					cmd_pop = 1'b1;
					do_push = cnt_cur < CNT_W'(RING_DEPTH);
				end else if (head_start) begin
					cmd_pop = 1'b1;
					do_pop  = 1'b1;
				end else if (head_read && out_free) begin
					cmd_pop   = 1'b1;
					load_stat = 1'b1;
					if (cmd.data.bad) begin
						stat_code = STAT_BAD;
					end else begin
						stat_rem = REM_W'(cnt_cur);
					end
				end
			end
			B_LOAD: begin
				if (out_free) begin
					load_evt = 1'b1;
					do_pop   = !last_q;
				end
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	assign cmd.ready = cmd_pop;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ring_mem[idx][wp_cur] <= cmd.data.evt;
		end
		if (do_pop) begin
			rd_q <= ring_mem[idx][rp_cur];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEVICES; i++) begin
				wp_q[i]  <= '0;
				rp_q[i]  <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			if (do_push) begin
				wp_q[idx]  <= wp_inc;
				cnt_q[idx] <= cnt_cur + CNT_W'(1);
			end
			if (do_pop) begin
				rp_q[idx]  <= rp_inc;
				cnt_q[idx] <= cnt_cur - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			dev_q   <= '0;
			rem_q   <= '0;
			last_q  <= 1'b0;
			left_q  <= '0;
		end else begin
			state_q <= state_d;
			if (do_pop) begin
				dev_q  <= idx;
				rem_q  <= meta_rem;
				last_q <= meta_last;
				left_q <= meta_left;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_evt || load_stat) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_evt) begin
			out_q.status      <= STAT_EVENT;
			out_q.stamp_sec   <= rd_q.sec;
			out_q.stamp_usec  <= rd_q.usec;
			out_q.event_type  <= rd_q.etype;
			out_q.event_code  <= rd_q.code;
			out_q.event_value <= rd_q.value;
			out_q.remaining   <= REM_W'(rem_q);
			out_q.last        <= last_q;
		end else if (load_stat) begin
			out_q.status      <= stat_code;
			out_q.stamp_sec   <= '0;
			out_q.stamp_usec  <= '0;
			out_q.event_type  <= '0;
			out_q.event_code  <= '0;
			out_q.event_value <= '0;
			out_q.remaining   <= stat_rem;
			out_q.last        <= 1'b1;
		end
	end

endmodule

/* rtl/core/timestamped_input_event_queues_top.sv */
// top level of the timestamped input event queues
// req carries items: tick, key post, relative post, button post or read.
// rsp carries result beats; only reads give results, one per popped event,
// or a single status beat when nothing is popped or the device is bad.
// cfg writes the device enable register; it is always ready.
// a tick issues no ring command, a key or button post up to two and a relative
// post up to three; the front end issues one ring command per cycle while the
// four-entry command queue has room, and the ring engine does one memory write
// per push unless the ring is full. with the block otherwise idle, a read's
// first event beat passes the front end, command queue, memory read and output
// registers before it is on rsp, and a status beat all but the memory read;
// further pops follow one per cycle while rsp is ready.
// if rsp stalls, the output register holds the beat and popping pauses;
// pushes and reads queue up to the command queue depth before req drops ready.
// reset clears the tick count, all ring pointers and counts, and sets the
// enable register to devices 0 and 1; ring contents are not cleared.
module timestamped_input_event_queues_top import tieq_pkg::*; #(
	parameter int DEVICES    = DEVICES_DEF,
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int TICK_RATE  = TICK_RATE_DEF
) (
	input logic         clk,
	input logic         arst_n,
	tieq_chan_if.sink   req,
	tieq_chan_if.source rsp,
	tieq_chan_if.sink   cfg
);

	tieq_chan_if #(.payload_t(cmd_t)) fq_if ();
	tieq_chan_if #(.payload_t(cmd_t)) bq_if ();

	tieq_front #(
		.DEVICES   (DEVICES),
		.TICK_RATE (TICK_RATE)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg),
		.cmd    (fq_if)
	);

	tieq_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fq_if),
		.rd     (bq_if)
	);

	tieq_back #(
		.DEVICES    (DEVICES),
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (bq_if),
		.rsp    (rsp)
	);

	// the front end only holds off req while it has a command on offer
	assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> fq_if.valid)
		else $error("req stalled with no command pending");

	// only event beats may be followed by more beats of the same read
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.data.last |-> rsp.data.status == STAT_EVENT)
		else $error("status beat without last");

	// microseconds always below one second
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.data.stamp_usec < USEC_W'(USEC_PER_SEC))
		else $error("stamp_usec out of range");

endmodule
